>>> rtl/core/assert_macros.svh
// Assertion macros shared by the deque RTL.
// Define NO_ASSERTIONS to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check a property on every clock edge outside reset.
`define DQ_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Check that a condition in one cycle implies a property in the next.
`define DQ_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) pre |=> post) else $error(msg);
`else
`define DQ_ASSERT(label, prop, msg)
`define DQ_ASSERT_NEXT(label, pre, post, msg)
`endif
`endif

>>> rtl/core/dq_pkg.sv
// Package for the double-ended queue: field widths, operation and status codes,
// controller/datapath handshake structs. No dependencies.
package dq_pkg;

	// Default sizing
	localparam int DQ_CAPACITY  = 16;
	localparam int DQ_WORD_BITS = 32;

	// Fixed field widths
	localparam int DQ_MODE_W   = 2;
	localparam int DQ_VALUE_W  = 32;
	localparam int DQ_STATUS_W = 2;
	localparam int DQ_OCC_W    = 5;

	// Operation codes
	localparam logic [DQ_MODE_W-1:0] MODE_PUSH_FRONT = 2'd0;
	localparam logic [DQ_MODE_W-1:0] MODE_PUSH_BACK  = 2'd1;
	localparam logic [DQ_MODE_W-1:0] MODE_POP_FRONT  = 2'd2;
	localparam logic [DQ_MODE_W-1:0] MODE_POP_BACK   = 2'd3;

	// Result status codes
	localparam logic [DQ_STATUS_W-1:0] STATUS_OK         = 2'd0;
	localparam logic [DQ_STATUS_W-1:0] STATUS_POP_EMPTY  = 2'd1;
	localparam logic [DQ_STATUS_W-1:0] STATUS_PUSH_FULL  = 2'd2;

	// Word returned when nothing is popped
	localparam logic [DQ_VALUE_W-1:0] NO_WORD = '1;

	// Controller to datapath
	typedef struct packed {
		logic take;   // latch the accepted request
		logic exec;   // apply the operation to indices, count and store
		logic fetch;  // load the read word into the result register
	} dq_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic rd_pending;  // the operation in flight issued a store read
	} dq_sts_t;

endpackage

>>> rtl/core/dq_req_if.sv
// Request channel of the deque: valid/ready plus operation code and word.
// Depends on dq_pkg.
interface dq_req_if;
	import dq_pkg::*;

	logic                         valid;
	logic                         ready;
	logic [DQ_MODE_W-1:0]         mode;
	logic signed [DQ_VALUE_W-1:0] value;

	modport source (output valid, mode, value, input ready);
	modport sink (input valid, mode, value, output ready);
endinterface

>>> rtl/core/dq_rsp_if.sv
// Result channel of the deque: valid/ready plus popped word and status fields.
// Depends on dq_pkg.
interface dq_rsp_if;
	import dq_pkg::*;

	logic                         valid;
	logic                         ready;
	logic signed [DQ_VALUE_W-1:0] popped_word;
	logic [DQ_STATUS_W-1:0]       status;
	logic [DQ_OCC_W-1:0]          occupancy;
	logic                         is_empty;

	modport source (output valid, popped_word, status, occupancy, is_empty, input ready);
	modport sink (input valid, popped_word, status, occupancy, is_empty, output ready);
endinterface

>>> rtl/core/dq_ctrl.sv
// Sequencer of the deque: accept, execute, fetch the read word, present the result.
// Depends on dq_pkg.
module dq_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	output dq_pkg::dq_cmd_t cmd,
	input  dq_pkg::dq_sts_t sts
);
	import dq_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_LOAD,
		S_OUT
	} state_t;

	state_t state_q;
	logic   in_ready_q;
	logic   out_valid_q;

	// Decode commands from the current state
	always_comb begin
		cmd.take  = in_valid & in_ready_q;
		cmd.exec  = (state_q == S_EXEC);
		cmd.fetch = (state_q == S_LOAD);
	end

	// Advance the sequence; hold the result until its transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			in_ready_q  <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && in_ready_q) begin
						state_q    <= S_EXEC;
						in_ready_q <= 1'b0;
					end
				end
				S_EXEC: begin
					if (sts.rd_pending) begin
						state_q <= S_LOAD;
					end else begin
						state_q     <= S_OUT;
						out_valid_q <= 1'b1;
					end
				end
				S_LOAD: begin
					state_q     <= S_OUT;
					out_valid_q <= 1'b1;
				end
				S_OUT: begin
					if (out_ready) begin
						state_q     <= S_IDLE;
						out_valid_q <= 1'b0;
						in_ready_q  <= 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ready  = in_ready_q;
	assign out_valid = out_valid_q;

endmodule

>>> rtl/core/dq_dp.sv
// Datapath of the deque: ring store, front/back indices, word count, result register.
// Depends on dq_pkg and assert_macros.svh.
`include "assert_macros.svh"
module dq_dp #(
	parameter int CAPACITY  = dq_pkg::DQ_CAPACITY,
	parameter int WORD_BITS = dq_pkg::DQ_WORD_BITS
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  dq_pkg::dq_cmd_t                      cmd,
	output dq_pkg::dq_sts_t                      sts,
	input  logic [dq_pkg::DQ_MODE_W-1:0]         mode,
	input  logic signed [dq_pkg::DQ_VALUE_W-1:0] value,
	output logic signed [dq_pkg::DQ_VALUE_W-1:0] popped_word,
	output logic [dq_pkg::DQ_STATUS_W-1:0]       status,
	output logic [dq_pkg::DQ_OCC_W-1:0]          occupancy,
	output logic                                 is_empty
);
	import dq_pkg::*;

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);

	// Request registers
	logic [DQ_MODE_W-1:0]  mode_q;
	logic [DQ_VALUE_W-1:0] value_q;

	// Ring state
	logic [WORD_BITS-1:0] ring_q [CAPACITY];
	logic [WORD_BITS-1:0] rdata_q;
	logic [IDX_W-1:0]     front_q;
	logic [IDX_W-1:0]     back_q;
	logic [CNT_W-1:0]     count_q;

	// Result registers
	logic [DQ_VALUE_W-1:0]  popped_q;
	logic [DQ_STATUS_W-1:0] status_q;
	logic [DQ_OCC_W-1:0]    occ_q;
	logic                   empty_q;

	logic                  is_push;
	logic                  full;
	logic                  empty;
	logic [IDX_W-1:0]      front_prev;
	logic [IDX_W-1:0]      front_next;
	logic [IDX_W-1:0]      back_prev;
	logic [IDX_W-1:0]      back_next;
	logic                  do_write;
	logic                  do_read;
	logic [IDX_W-1:0]      wr_addr;
	logic [IDX_W-1:0]      rd_addr;
	logic [WORD_BITS-1:0]  wdata;
	logic [DQ_VALUE_W-1:0] rd_word;
	logic [IDX_W-1:0]      front_d;
	logic [IDX_W-1:0]      back_d;
	logic [CNT_W-1:0]      count_d;
	logic [DQ_STATUS_W-1:0] status_d;

	// Latch the accepted request
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			mode_q  <= mode;
			value_q <= value;
		end
	end

	// Resize the word between request width, store width and result width
	generate
		if (WORD_BITS > DQ_VALUE_W) begin : g_wide
			assign wdata   = {{(WORD_BITS - DQ_VALUE_W){value_q[DQ_VALUE_W-1]}}, value_q};
			assign rd_word = rdata_q[DQ_VALUE_W-1:0];
		end else if (WORD_BITS == DQ_VALUE_W) begin : g_equal
			assign wdata   = value_q;
			assign rd_word = rdata_q;
		end else begin : g_narrow
			assign wdata   = value_q[WORD_BITS-1:0];
			assign rd_word = {{(DQ_VALUE_W - WORD_BITS){1'b0}}, rdata_q};
		end
	endgenerate

	// Wrap the indices around the ring
	always_comb begin
		front_prev = (front_q == '0) ? LAST_IDX : front_q - IDX_W'(1);
		front_next = (front_q == LAST_IDX) ? '0 : front_q + IDX_W'(1);
		back_prev  = (back_q == '0) ? LAST_IDX : back_q - IDX_W'(1);
		back_next  = (back_q == LAST_IDX) ? '0 : back_q + IDX_W'(1);
	end

	// Decide the operation and the next index and count values
	always_comb begin
		is_push  = ~mode_q[1];
		full     = (count_q == FULL_CNT);
		empty    = (count_q == '0);
		do_write = cmd.exec & is_push & ~full;
		do_read  = cmd.exec & ~is_push & ~empty;
		wr_addr  = (mode_q == MODE_PUSH_FRONT) ? front_prev : back_q;
		rd_addr  = (mode_q == MODE_POP_FRONT) ? front_q : back_prev;
		front_d  = front_q;
		back_d   = back_q;
		count_d  = count_q;
		status_d = STATUS_OK;
		unique case (mode_q)
			MODE_PUSH_FRONT: begin
				if (full) begin
					status_d = STATUS_PUSH_FULL;
				end else begin
					front_d = front_prev;
					count_d = count_q + CNT_W'(1);
				end
			end
			MODE_PUSH_BACK: begin
				if (full) begin
					status_d = STATUS_PUSH_FULL;
				end else begin
					back_d  = back_next;
					count_d = count_q + CNT_W'(1);
				end
			end
			MODE_POP_FRONT: begin
				if (empty) begin
					status_d = STATUS_POP_EMPTY;
				end else begin
					front_d = front_next;
					count_d = count_q - CNT_W'(1);
				end
			end
			MODE_POP_BACK: begin
				if (empty) begin
					status_d = STATUS_POP_EMPTY;
				end else begin
					back_d  = back_prev;
					count_d = count_q - CNT_W'(1);
				end
			end
			default: begin
				status_d = STATUS_OK;
			end
		endcase
	end

	assign sts.rd_pending = do_read;

	// Write and read the ring store
	always_ff @(posedge clk) begin
		if (do_write) begin
			ring_q[wr_addr] <= wdata;
		end
		if (do_read) begin
			rdata_q <= ring_q[rd_addr];
		end
	end

	// Update indices and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			back_q  <= '0;
			count_q <= '0;
		end else if (cmd.exec) begin
			front_q <= front_d;
			back_q  <= back_d;
			count_q <= count_d;
		end
	end

	// Load the result fields, then the popped word once it is read
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			popped_q <= NO_WORD;
			status_q <= status_d;
			occ_q    <= DQ_OCC_W'(count_d);
			empty_q  <= (count_d == '0);
		end else if (cmd.fetch) begin
			popped_q <= rd_word;
		end
	end

	assign popped_word = popped_q;
	assign status      = status_q;
	assign occupancy   = occ_q;
	assign is_empty    = empty_q;

	`DQ_ASSERT(a_count_bound, count_q <= FULL_CNT, "word count exceeds capacity")
	`DQ_ASSERT(a_ring_wrap, (count_q == '0 || count_q == FULL_CNT) |-> front_q == back_q, "indices disagree with empty or full count")
	`DQ_ASSERT_NEXT(a_count_hold, !cmd.exec, $stable(count_q), "word count changed outside execute")
	`DQ_ASSERT(a_no_overlap, !(do_write && do_read), "store written and read by one operation")

endmodule

>>> rtl/core/double_ended_queue.sv
// Bounded double-ended queue of signed words.
// Channels: req (valid/ready; mode, value) and rsp (valid/ready; popped_word,
// status, occupancy, is_empty). A transfer occurs when valid and ready are both high.
// Each request is one of push front, push back, pop front, pop back and yields
// exactly one result. A pop on an empty queue returns all ones with status pop-empty;
// a push on a full queue is dropped with status push-full and returns all ones.
// Timing: one request is in flight at a time. rsp.valid rises after the execute state for a
// push or a pop on an empty queue, and after an added fetch state for any other pop, the
// registered read of the ring store. A new request is taken only once the previous result
// has transferred (the states run idle, execute, optional fetch, output).
// Stall: while rsp.ready is low the result is held and req.ready stays low.
// Reset (arst_n low): the queue empties, indices and count clear, no result pending.
// The ring store itself is not cleared; only written slots are ever read.
// Depends on dq_pkg, dq_req_if, dq_rsp_if, dq_ctrl, dq_dp.
module double_ended_queue #(
	parameter int CAPACITY  = dq_pkg::DQ_CAPACITY,
	parameter int WORD_BITS = dq_pkg::DQ_WORD_BITS
) (
	input logic      clk,
	input logic      arst_n,
	dq_req_if.sink   req,
	dq_rsp_if.source rsp
);
	import dq_pkg::*;

	dq_cmd_t cmd;
	dq_sts_t sts;

	// Sequence each request
	dq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	// Hold the ring and compute results
	dq_dp #(
		.CAPACITY  (CAPACITY),
		.WORD_BITS (WORD_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.mode        (req.mode),
		.value       (req.value),
		.popped_word (rsp.popped_word),
		.status      (rsp.status),
		.occupancy   (rsp.occupancy),
		.is_empty    (rsp.is_empty)
	);

endmodule
